>>> hw/rtl/sost_pkg.sv
// sum-over-subsets transform: shared constants, item types and state encodings
// used by sost_sweep and sum_over_subsets_transform_core; no dependencies
package sost_pkg;

  localparam int LOG_ENTRIES = 10;
  localparam int VALUE_BITS  = 32;
  localparam int ENTRIES     = 1 << LOG_ENTRIES;

  localparam int INDEX_W = 10;
  localparam int FIELD_W = 32;
  localparam int CFG_W   = 4;
  localparam int EFF_W   = ($clog2(LOG_ENTRIES + 1) > CFG_W) ? $clog2(LOG_ENTRIES + 1) : CFG_W;

  localparam logic [CFG_W-1:0] ACTIVE_BITS_RESET = CFG_W'(10);

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_RUN    = 2'd1,
    CMD_READ   = 2'd2,
    CMD_UNUSED = 2'd3
  } command_t;

  typedef enum logic {
    KIND_READ = 1'b0,
    KIND_DONE = 1'b1
  } kind_t;

  typedef struct packed {
    command_t                   command;
    logic [INDEX_W-1:0]         index;
    logic signed [FIELD_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    kind_t                      kind;
    logic [INDEX_W-1:0]         entry_index;
    logic signed [FIELD_W-1:0]  entry_value;
  } out_item_t;

  typedef struct packed {
    logic                       rd_en;
    logic [LOG_ENTRIES-1:0]     rd_addr_a;
    logic [LOG_ENTRIES-1:0]     rd_addr_b;
    logic                       wr_en;
    logic [LOG_ENTRIES-1:0]     wr_addr;
    logic [VALUE_BITS-1:0]      wr_data;
  } sweep_req_t;

  typedef enum logic [1:0] {
    SW_IDLE,
    SW_ISSUE,
    SW_DRAIN
  } sweep_state_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_READ,
    T_RUN,
    T_DONE
  } top_state_t;

endpackage

>>> hw/rtl/sost_ram.sv
// table memory: one write port and two read ports, read data registered
// generic module, no package dependency
module sost_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re_a,
  input  logic [ADDR_W-1:0] raddr_a,
  output logic [DATA_W-1:0] rdata_a,
  input  logic              re_b,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> hw/rtl/sost_sweep.sv
// transform sequencer: walks bit passes and entries, reads pairs, writes sums back
// depends on sost_pkg
module sost_sweep (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [sost_pkg::EFF_W-1:0]         eff_bits,
  input  logic [sost_pkg::VALUE_BITS-1:0]    rdata_a,
  input  logic [sost_pkg::VALUE_BITS-1:0]    rdata_b,
  output sost_pkg::sweep_req_t               req,
  output logic                               done
);

  localparam logic [sost_pkg::LOG_ENTRIES-1:0] ONE = sost_pkg::LOG_ENTRIES'(1);

  sost_pkg::sweep_state_t            state, state_next;
  logic [sost_pkg::EFF_W-1:0]        bit_pos, bit_pos_next;
  logic [sost_pkg::LOG_ENTRIES-1:0]  k, k_next;
  logic                              done_next;
  logic                              wb_valid;
  logic [sost_pkg::LOG_ENTRIES-1:0]  wb_addr;
  logic [sost_pkg::LOG_ENTRIES-1:0]  bit_mask, low_mask, half_last, m;

  // entry with the current bit set, built by inserting a one into k
  assign bit_mask  = ONE << bit_pos;
  assign low_mask  = bit_mask - ONE;
  assign m         = ((k & ~low_mask) << 1) | bit_mask | (k & low_mask);
  assign half_last = (ONE << (eff_bits - sost_pkg::EFF_W'(1))) - ONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sost_pkg::SW_IDLE;
      done     <= 1'b0;
      wb_valid <= 1'b0;
      bit_pos  <= '0;
      k        <= '0;
    end else begin
      state    <= state_next;
      done     <= done_next;
      wb_valid <= (state == sost_pkg::SW_ISSUE);
      bit_pos  <= bit_pos_next;
      k        <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr <= m;
  end

  always_comb begin
    state_next   = state;
    bit_pos_next = bit_pos;
    k_next       = k;
    done_next    = 1'b0;
    req.rd_en    = 1'b0;
    req.rd_addr_a = m;
    req.rd_addr_b = m & ~bit_mask;
    req.wr_en    = wb_valid;
    req.wr_addr  = wb_addr;
    req.wr_data  = rdata_a + rdata_b;
    case (state)
      sost_pkg::SW_IDLE: begin
        if (start) begin
          bit_pos_next = '0;
          k_next       = '0;
          if (eff_bits == '0) begin
            done_next = 1'b1;
          end else begin
            state_next = sost_pkg::SW_ISSUE;
          end
        end
      end
      sost_pkg::SW_ISSUE: begin
        req.rd_en = 1'b1;
        if (k == half_last) begin
          state_next = sost_pkg::SW_DRAIN;
        end else begin
          k_next = k + ONE;
        end
      end
      sost_pkg::SW_DRAIN: begin
        // last write-back of the pass lands here
        if (bit_pos == eff_bits - sost_pkg::EFF_W'(1)) begin
          done_next  = 1'b1;
          state_next = sost_pkg::SW_IDLE;
        end else begin
          bit_pos_next = bit_pos + sost_pkg::EFF_W'(1);
          k_next       = '0;
          state_next   = sost_pkg::SW_ISSUE;
        end
      end
      default: begin
        state_next = sost_pkg::SW_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/sum_over_subsets_transform_core.sv
// sum-over-subsets transform core: command decode, table memory, result register
// depends on sost_pkg, sost_ram, sost_sweep
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     sost_pkg::in_item_t
//   rsp      out        rsp_valid / rsp_ready     sost_pkg::out_item_t
//   cfg      in         cfg_we                    cfg_wdata (active_bits)
//
// write item: written at accept; read item: data from the registered memory read port in T_READ
// run item: one entry update per cycle through the two-read one-write table memory,
//   a SW_DRAIN state between bit passes
// reset clears control state only; table contents are undefined until written
// a read or run waits at its end for a free result register and holds the input
// meanwhile; writes go in while nothing is pending
module sum_over_subsets_transform_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  sost_pkg::in_item_t            req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output sost_pkg::out_item_t           rsp,
  input  logic                          cfg_we,
  input  logic [sost_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam logic [sost_pkg::LOG_ENTRIES-1:0] ONE = sost_pkg::LOG_ENTRIES'(1);

  sost_pkg::top_state_t                 state, state_next;
  logic [sost_pkg::CFG_W-1:0]           active_bits;
  logic [sost_pkg::EFF_W-1:0]           eff_bits;
  logic [sost_pkg::LOG_ENTRIES-1:0]     sel_mask, idx_in, rd_idx;
  logic                                 accept, out_free, load;
  sost_pkg::out_item_t                  rsp_next;
  logic                                 sweep_start, sweep_done;
  sost_pkg::sweep_req_t                 sw;
  logic                                 ram_we, ram_re_a;
  logic [sost_pkg::LOG_ENTRIES-1:0]     ram_waddr, ram_raddr_a;
  logic [sost_pkg::VALUE_BITS-1:0]      ram_wdata, rdata_a, rdata_b;

  assign eff_bits = (sost_pkg::EFF_W'(active_bits) > sost_pkg::EFF_W'(sost_pkg::LOG_ENTRIES))
                    ? sost_pkg::EFF_W'(sost_pkg::LOG_ENTRIES) : sost_pkg::EFF_W'(active_bits);
  assign sel_mask = (ONE << eff_bits) - ONE;
  assign idx_in   = sost_pkg::LOG_ENTRIES'(req.index) & sel_mask;

  assign req_ready = (state == sost_pkg::T_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  // sweep owns the memory only while a run is active
  assign ram_re_a    = sw.rd_en || (accept && req.command == sost_pkg::CMD_READ);
  assign ram_raddr_a = sw.rd_en ? sw.rd_addr_a : idx_in;
  assign ram_we      = sw.wr_en || (accept && req.command == sost_pkg::CMD_WRITE);
  assign ram_waddr   = sw.wr_en ? sw.wr_addr : idx_in;
  assign ram_wdata   = sw.wr_en ? sw.wr_data : sost_pkg::VALUE_BITS'(req.value);

  sost_ram #(
    .ADDR_W (sost_pkg::LOG_ENTRIES),
    .DATA_W (sost_pkg::VALUE_BITS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re_a    (ram_re_a),
    .raddr_a (ram_raddr_a),
    .rdata_a (rdata_a),
    .re_b    (sw.rd_en),
    .raddr_b (sw.rd_addr_b),
    .rdata_b (rdata_b)
  );

  sost_sweep u_sweep (
    .clk      (clk),
    .rst      (rst),
    .start    (sweep_start),
    .eff_bits (eff_bits),
    .rdata_a  (rdata_a),
    .rdata_b  (rdata_b),
    .req      (sw),
    .done     (sweep_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sost_pkg::T_IDLE;
      active_bits <= sost_pkg::ACTIVE_BITS_RESET;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        active_bits <= cfg_wdata;
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= rsp_next;
    end
    if (accept) begin
      rd_idx <= idx_in;
    end
  end

  always_comb begin
    state_next           = state;
    sweep_start          = 1'b0;
    load                 = 1'b0;
    rsp_next.kind        = sost_pkg::KIND_READ;
    rsp_next.entry_index = sost_pkg::INDEX_W'(rd_idx);
    rsp_next.entry_value = sost_pkg::FIELD_W'($signed(rdata_a));
    case (state)
      sost_pkg::T_IDLE: begin
        if (accept) begin
          case (req.command)
            sost_pkg::CMD_READ: begin
              state_next = sost_pkg::T_READ;
            end
            sost_pkg::CMD_RUN: begin
              sweep_start = 1'b1;
              state_next  = sost_pkg::T_RUN;
            end
            default: begin
              state_next = sost_pkg::T_IDLE;
            end
          endcase
        end
      end
      sost_pkg::T_READ: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = sost_pkg::T_IDLE;
        end
      end
      sost_pkg::T_RUN: begin
        if (sweep_done) begin
          state_next = sost_pkg::T_DONE;
        end
      end
      sost_pkg::T_DONE: begin
        rsp_next.kind        = sost_pkg::KIND_DONE;
        rsp_next.entry_index = '0;
        rsp_next.entry_value = '0;
        if (out_free) begin
          load       = 1'b1;
          state_next = sost_pkg::T_IDLE;
        end
      end
      default: begin
        state_next = sost_pkg::T_IDLE;
      end
    endcase
  end

endmodule

>>> test/tb_top.sv
// self-checking bench for sum_over_subsets_transform_core: a directed table, then phases
// of random table writes, reads and transform runs checked against a shadow table
// depends on sost_pkg and the core rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ITEMS    = 1550;
  localparam int N_DIRECTED = 21;
  localparam int N_PHASES   = 22;

  typedef struct packed {
    sost_pkg::command_t                command;
    logic [sost_pkg::INDEX_W-1:0]      index;
    logic [sost_pkg::FIELD_W-1:0]      value;
    logic                              fixed;
    sost_pkg::out_item_t               want;
  } op_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  sost_pkg::in_item_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  sost_pkg::out_item_t rsp;
  logic cfg_we = 1'b0;
  logic [sost_pkg::CFG_W-1:0] cfg_wdata = '0;

  sum_over_subsets_transform_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the table and of active_bits
  logic [sost_pkg::VALUE_BITS-1:0] shadow_mem [sost_pkg::ENTRIES];
  bit                              shadow_known [sost_pkg::ENTRIES];
  logic [sost_pkg::CFG_W-1:0]      shadow_bits = sost_pkg::ACTIVE_BITS_RESET;

  sost_pkg::out_item_t expected_rsp_q [$];

  int send_idle_pct = 12;
  int recv_idle_pct = 77;
  logic hold_rsp = 1'b0;

  int mismatch_count = 0;
  int accepted_items = 0;
  int n_writes = 0;
  int n_reads = 0;
  int n_runs = 0;
  int n_ignored = 0;
  int n_cfg = 0;

  // expected results are typed in only where obvious; the rest come from the shadow table
  op_row_t directed_rows [N_DIRECTED] = '{
    '{sost_pkg::CMD_WRITE,  10'd0,    32'h7fff_ffff, 1'b0, '0},
    '{sost_pkg::CMD_WRITE,  10'd1023, 32'h8000_0000, 1'b0, '0},
    '{sost_pkg::CMD_READ,   10'd0,    32'h0000_0000, 1'b1,
      '{sost_pkg::KIND_READ, 10'd0, 32'h7fff_ffff}},
    '{sost_pkg::CMD_READ,   10'd1023, 32'hffff_ffff, 1'b1,
      '{sost_pkg::KIND_READ, 10'd1023, 32'h8000_0000}},
    '{sost_pkg::CMD_WRITE,  10'd1,    32'hffff_ffff, 1'b0, '0},
    '{sost_pkg::CMD_WRITE,  10'd2,    32'h0000_0001, 1'b0, '0},
    '{sost_pkg::CMD_WRITE,  10'd3,    32'h0000_0000, 1'b0, '0},
    '{sost_pkg::CMD_UNUSED, 10'd5,    32'h1234_5678, 1'b0, '0},
    '{sost_pkg::CMD_READ,   10'd1,    32'h0000_0000, 1'b1,
      '{sost_pkg::KIND_READ, 10'd1, 32'hffff_ffff}},
    '{sost_pkg::CMD_WRITE,  10'd0,    32'h0000_0000, 1'b0, '0},
    '{sost_pkg::CMD_RUN,    10'd0,    32'h0000_0000, 1'b1,
      '{sost_pkg::KIND_DONE, 10'd0, 32'h0000_0000}},
    '{sost_pkg::CMD_READ,   10'd3,    32'h0000_0000, 1'b0, '0},
    '{sost_pkg::CMD_READ,   10'd1,    32'h0000_0000, 1'b0, '0},
    '{sost_pkg::CMD_READ,   10'd2,    32'h0000_0000, 1'b0, '0},
    '{sost_pkg::CMD_WRITE,  10'd0,    32'h8000_0000, 1'b0, '0},
    '{sost_pkg::CMD_WRITE,  10'd3,    32'h8000_0000, 1'b0, '0},
    '{sost_pkg::CMD_RUN,    10'd1023, 32'hffff_ffff, 1'b1,
      '{sost_pkg::KIND_DONE, 10'd0, 32'h0000_0000}},
    '{sost_pkg::CMD_READ,   10'd3,    32'h0000_0000, 1'b0, '0},
    '{sost_pkg::CMD_UNUSED, 10'd1023, 32'hffff_ffff, 1'b0, '0},
    '{sost_pkg::CMD_READ,   10'd0,    32'h0000_0000, 1'b0, '0},
    '{sost_pkg::CMD_READ,   10'd2,    32'h0000_0000, 1'b0, '0}
  };

  logic [sost_pkg::CFG_W-1:0] phase_bits [N_PHASES] = '{
    4'd0, 4'd3, 4'd1, 4'd15, 4'd2, 4'd5, 4'd10, 4'd4, 4'd6, 4'd0, 4'd12,
    4'd3, 4'd7, 4'd2, 4'd8, 4'd11, 4'd1, 4'd9, 4'd5, 4'd13, 4'd4, 4'd14
  };

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    rsp_ready <= !hold_rsp && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : rsp_check
    sost_pkg::out_item_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp_q.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: kind %0d index %0d value %h",
                   rsp.kind, rsp.entry_index, rsp.entry_value);
        mismatch_count++;
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp.kind !== want.kind || rsp.entry_index !== want.entry_index ||
            rsp.entry_value !== want.entry_value) begin
          if (mismatch_count < 10)
            $display("mismatch: expected kind %0d index %0d value %h, %s %0d %0d %h",
                     want.kind, want.entry_index, want.entry_value, "got",
                     rsp.kind, rsp.entry_index, rsp.entry_value);
          mismatch_count++;
        end
      end
    end
  end

  task automatic predict_table_op(input sost_pkg::in_item_t it, output bit has_rsp,
                                  output sost_pkg::out_item_t want);
    int eff;
    logic [sost_pkg::INDEX_W-1:0] idx;
    logic [sost_pkg::LOG_ENTRIES-1:0] hi;
    logic [sost_pkg::LOG_ENTRIES-1:0] lo;
    eff = (shadow_bits > sost_pkg::LOG_ENTRIES) ? sost_pkg::LOG_ENTRIES
                                                : int'(shadow_bits);
    idx = it.index & sost_pkg::INDEX_W'((1 << eff) - 1);
    has_rsp = 1'b0;
    want = '0;
    case (it.command)
      sost_pkg::CMD_WRITE: begin
        shadow_mem[idx] = it.value;
        shadow_known[idx] = 1'b1;
      end
      sost_pkg::CMD_RUN: begin
        for (int b = 0; b < eff; b++) begin
          for (int m = 0; m < (1 << eff); m++) begin
            hi = sost_pkg::LOG_ENTRIES'(m);
            lo = sost_pkg::LOG_ENTRIES'(m ^ (1 << b));
            if (hi[b]) begin
              shadow_mem[hi] = shadow_mem[hi] + shadow_mem[lo];
              shadow_known[hi] = shadow_known[hi] && shadow_known[lo];
            end
          end
        end
        has_rsp = 1'b1;
        want.kind = sost_pkg::KIND_DONE;
      end
      sost_pkg::CMD_READ: begin
        has_rsp = 1'b1;
        want.kind = sost_pkg::KIND_READ;
        want.entry_index = idx;
        want.entry_value = shadow_mem[idx];
      end
      default: begin
      end
    endcase
  endtask

  task automatic offer_command(input sost_pkg::in_item_t it, input bit use_fixed,
                               input sost_pkg::out_item_t fixed_rsp);
    int gap;
    bit has_rsp;
    sost_pkg::out_item_t want;
    if (accepted_items < 540) begin
      send_idle_pct = 12;
      recv_idle_pct <= 77;
    end else if (accepted_items < 1080) begin
      send_idle_pct = 77;
      recv_idle_pct <= 12;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct <= 0;
    end
    gap = 0;
    while (gap < 6 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= it;
    do @(posedge clk); while (!req_ready);
    predict_table_op(it, has_rsp, want);
    if (has_rsp) begin
      if (use_fixed) want = fixed_rsp;
      expected_rsp_q = {expected_rsp_q, want};
    end
    case (it.command)
      sost_pkg::CMD_WRITE: n_writes++;
      sost_pkg::CMD_READ:  n_reads++;
      sost_pkg::CMD_RUN:   n_runs++;
      default:             n_ignored++;
    endcase
    accepted_items++;
  endtask

  // only while idle: all results in and the last write item through the core
  task automatic set_active_bits(input logic [sost_pkg::CFG_W-1:0] bits);
    req_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= bits;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_bits = bits;
    n_cfg++;
  endtask

  function automatic logic [sost_pkg::FIELD_W-1:0] rand_value();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic run_phase(input logic [sost_pkg::CFG_W-1:0] bits, input bit with_holdoff);
    int eff;
    int size;
    int fill;
    int steps;
    int runs_left;
    int pick;
    int start;
    int found;
    logic [sost_pkg::INDEX_W-1:0] idx_mask;
    logic [sost_pkg::LOG_ENTRIES-1:0] slot;
    sost_pkg::in_item_t it;
    set_active_bits(bits);
    eff = (bits > sost_pkg::LOG_ENTRIES) ? sost_pkg::LOG_ENTRIES : int'(bits);
    size = 1 << eff;
    idx_mask = sost_pkg::INDEX_W'(size - 1);
    fill = (size < 32) ? size : 32;
    // low entries first, so the submasks of every filled index are filled too
    for (int i = 0; i < fill; i++) begin
      it.command = sost_pkg::CMD_WRITE;
      it.index = (sost_pkg::INDEX_W'($urandom()) & ~idx_mask) | sost_pkg::INDEX_W'(i);
      it.value = rand_value();
      offer_command(it, 1'b0, '0);
    end
    if (with_holdoff) begin
      fork
        begin
          hold_rsp <= 1'b1;
          repeat (250) @(posedge clk);
          hold_rsp <= 1'b0;
        end
      join_none
    end
    runs_left = (eff >= 7) ? 1 : 4;
    steps = $urandom_range(30, 70);
    for (int s = 0; s < steps; s++) begin
      pick = $urandom_range(0, 99);
      it.index = sost_pkg::INDEX_W'($urandom());
      it.value = rand_value();
      if (pick < 5) begin
        it.command = sost_pkg::CMD_UNUSED;
      end else if (pick < 15 && runs_left > 0) begin
        it.command = sost_pkg::CMD_RUN;
        runs_left--;
      end else if (pick < 55) begin
        // read only entries whose value is defined
        start = $urandom_range(0, size - 1);
        found = -1;
        for (int j = 0; j < size && found < 0; j++) begin
          slot = sost_pkg::LOG_ENTRIES'((start + j) % size);
          if (shadow_known[slot]) found = int'(slot);
        end
        if (found >= 0) begin
          it.command = sost_pkg::CMD_READ;
          it.index = (it.index & ~idx_mask) | sost_pkg::INDEX_W'(found);
        end else begin
          it.command = sost_pkg::CMD_WRITE;
        end
      end else begin
        it.command = sost_pkg::CMD_WRITE;
      end
      offer_command(it, 1'b0, '0);
    end
  endtask

  initial begin
    sost_pkg::in_item_t it;
    int phase;
    foreach (shadow_mem[i]) begin
      shadow_mem[i] = '0;
      shadow_known[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < N_DIRECTED; r++) begin
      it.command = directed_rows[r].command;
      it.index = directed_rows[r].index;
      it.value = directed_rows[r].value;
      offer_command(it, directed_rows[r].fixed, directed_rows[r].want);
    end

    phase = 0;
    while (accepted_items < N_ITEMS) begin
      if (phase < N_PHASES)
        run_phase(phase_bits[phase], phase == 1);
      else
        run_phase(sost_pkg::CFG_W'($urandom_range(0, 6)), 1'b0);
      phase++;
    end
    req_valid <= 1'b0;

    for (int c = 0; c < 60000 && expected_rsp_q.size() != 0; c++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_rsp_q.size() != 0) begin
      $display("%0d results never arrived", expected_rsp_q.size());
      mismatch_count += expected_rsp_q.size();
    end

    $display("ran %0d writes, %0d reads, %0d transform runs, %0d ignored items over %0d phases",
             n_writes, n_reads, n_runs, n_ignored, phase);
    $display("%0d active_bits writes, %0d mismatches", n_cfg, mismatch_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
